// ===== sv/bilinear_image_sampler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Bilinear image sampler assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SAMPLER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication
`define BIS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear sampler check failed");

// next-cycle implication
`define BIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear sampler check failed");

`endif

// ===== sv/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear image sampler package
// Widths, field codes and register indexes shared by the sampler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int PIX_W      = 16;
    localparam int COORD_W    = 16;
    localparam int FRAC_BITS  = 8;
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int SIZE_W     = 9;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int WEIGHT_W   = 2 * FRAC_BITS + 1;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int BANK_AW    = 2 * (INT_W - 1);
    localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic [PIX_W-1:0]    pixel_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [BANK_AW-1:0]  bank_addr_t;

    // input action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_MAX_W = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] SIZE_MAX_H = SIZE_W'(MAX_HEIGHT);
    localparam weight_t           WEIGHT_ONE = WEIGHT_W'(1 << (2 * FRAC_BITS));
    localparam prod_t             ROUND_HALF = PROD_W'(1 << (2 * FRAC_BITS - 1));
    localparam pixel_t            SIGN_BIAS  = PIX_W'(1 << (PIX_W - 1));

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== sv/bilinear_image_sampler_top.sv =====
// A sample passes the stage 1, stage 2 and output registers before its result shows.
// Throughput: one transaction per cycle when in_stall is low, writes and samples
// alike; the pixel store is four single-port banks split by row and column parity,
// so all four neighbors are read in one access.
// Reset: sizes return to 256 x 256 and the pipeline empties; the pixel store is
// not cleared, so pixels must be written before they are sampled.
// ----------------------------------------------------------------------------
// Bilinear image sampler
// Pixel store with 8.8 fixed-point bilinear sampling, border and clamp logic.
// ----------------------------------------------------------------------------
`include "bilinear_image_sampler_top_defines.svh"

module bilinear_image_sampler_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [bis_pkg::INT_W-1:0]            pixel_col,
    input  logic [bis_pkg::INT_W-1:0]            pixel_row,
    input  logic signed [bis_pkg::PIX_W-1:0]     pixel_value,
    input  logic [bis_pkg::COORD_W-1:0]          sample_x,
    input  logic [bis_pkg::COORD_W-1:0]          sample_y,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bis_pkg::PIX_W-1:0]     sample_value,
    output logic                                 clamped,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bis_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bis_pkg::SIZE_W-1:0]           cfg_data
);

    localparam int IW = bis_pkg::INT_W;
    localparam int FB = bis_pkg::FRAC_BITS;
    localparam int SW = bis_pkg::SIZE_W;

    // ---------------- configuration ----------------
    logic [SW-1:0] width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bis_pkg::SIZE_MAX_W;
            height_reg <= bis_pkg::SIZE_MAX_H;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bis_pkg::CFG_IMAGE_WIDTH:
                    width_reg <= bis_pkg::fit_size(cfg_data, bis_pkg::SIZE_MAX_W);
                bis_pkg::CFG_IMAGE_HEIGHT:
                    height_reg <= bis_pkg::fit_size(cfg_data, bis_pkg::SIZE_MAX_H);
                default:
                    ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic en1, en2, en3;
    logic accept, do_sample, do_write;

    assign en3       = !out_valid_reg || !out_stall;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign in_stall  = !en1;
    assign accept    = in_valid && en1;
    assign do_sample = accept && (action == bis_pkg::ACT_SAMPLE);
    assign do_write  = accept && (action == bis_pkg::ACT_WRITE);

    // ---------------- stage 0: coordinate split, clamp, weights ----------------
    logic [IW-1:0] xi, yi, xi_c, yi_c;
    logic [FB-1:0] fx, fy;
    logic [FB:0]   gx, gy;
    logic          x_over, y_over, border;
    logic [SW-1:0] xi_inc, yi_inc;
    bis_pkg::weight_t w_next [2][2];
    bis_pkg::bank_addr_t raddr [4];

    assign xi = sample_x[bis_pkg::COORD_W-1:FB];
    assign yi = sample_y[bis_pkg::COORD_W-1:FB];
    assign fx = sample_x[FB-1:0];
    assign fy = sample_y[FB-1:0];

    assign x_over = {1'b0, xi} >= width_reg;
    assign y_over = {1'b0, yi} >= height_reg;
    assign xi_c   = x_over ? IW'(width_reg - SW'(1)) : xi;
    assign yi_c   = y_over ? IW'(height_reg - SW'(1)) : yi;
    assign xi_inc = {1'b0, xi_c} + SW'(1);
    assign yi_inc = {1'b0, yi_c} + SW'(1);
    assign border = (xi_inc >= width_reg) || (yi_inc >= height_reg);

    assign gx = (FB+1)'(1 << FB) - {1'b0, fx};
    assign gy = (FB+1)'(1 << FB) - {1'b0, fy};

    // border: all weight on the base pixel, which reproduces it exactly
    always_comb
    begin
        if (border)
        begin
            w_next[0][0] = bis_pkg::WEIGHT_ONE;
            w_next[0][1] = '0;
            w_next[1][0] = '0;
            w_next[1][1] = '0;
        end
        else
        begin
            w_next[0][0] = bis_pkg::WEIGHT_W'(gx * gy);
            w_next[0][1] = bis_pkg::WEIGHT_W'({1'b0, fx} * gy);
            w_next[1][0] = bis_pkg::WEIGHT_W'(gx * {1'b0, fy});
            w_next[1][1] = bis_pkg::WEIGHT_W'({1'b0, fx} * {1'b0, fy});
        end
    end

    // bank b = {row parity, col parity}; odd base steps the even bank forward
    always_comb
    begin
        logic [IW:0] rsum;
        logic [IW:0] csum;
        for (int b = 0; b < 4; b++)
        begin
            rsum = {1'b0, yi_c} + (IW+1)'(yi_c[0] & ~b[1]);
            csum = {1'b0, xi_c} + (IW+1)'(xi_c[0] & ~b[0]);
            raddr[b] = {rsum[IW-1:1], csum[IW-1:1]};
        end
    end

    // ---------------- pixel store ----------------
    bis_pkg::pixel_t     rd_reg [4];
    bis_pkg::bank_addr_t waddr;
    logic [1:0]          wbank;

    assign waddr = {pixel_row[IW-1:1], pixel_col[IW-1:1]};
    assign wbank = {pixel_row[0], pixel_col[0]};

    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        bis_pkg::pixel_t mem [bis_pkg::BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (do_write && (wbank == 2'(gb)))
                mem[waddr] <= pixel_value;
            if (do_sample)
                rd_reg[gb] <= mem[raddr[gb]];
        end
    end

    // ---------------- stage 1 registers ----------------
    bis_pkg::weight_t w_reg [2][2];
    logic             s1_clamp_reg;
    logic             s1_xpar_reg, s1_ypar_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= do_sample;
    end

    always_ff @(posedge clk)
    begin
        if (do_sample)
        begin
            w_reg        <= w_next;
            s1_clamp_reg <= x_over || y_over;
            s1_xpar_reg  <= xi_c[0];
            s1_ypar_reg  <= yi_c[0];
        end
    end

    // ---------------- stage 2: neighbor select and weighting ----------------
    bis_pkg::prod_t prod_next [2][2];
    bis_pkg::prod_t prod_reg  [2][2];
    logic           s2_clamp_reg;

    always_comb
    begin
        logic [1:0]      sel;
        bis_pkg::pixel_t pix;
        for (int dy = 0; dy < 2; dy++)
        begin
            for (int dx = 0; dx < 2; dx++)
            begin
                sel = {s1_ypar_reg ^ dy[0], s1_xpar_reg ^ dx[0]};
                pix = rd_reg[sel] ^ bis_pkg::SIGN_BIAS;
                prod_next[dy][dx] = bis_pkg::PROD_W'(w_reg[dy][dx] * pix);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            prod_reg     <= prod_next;
            s2_clamp_reg <= s1_clamp_reg;
        end
    end

    // ---------------- stage 3: sum, round, output register ----------------
    // weights sum to one, so the rounded sum never leaves the pixel range
    bis_pkg::prod_t  acc;
    bis_pkg::pixel_t value_reg;
    logic            clamp_reg;

    assign acc = prod_reg[0][0] + prod_reg[0][1] + prod_reg[1][0] + prod_reg[1][1]
               + bis_pkg::ROUND_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en3)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            value_reg <= acc[bis_pkg::PROD_W-1:2*FB] ^ bis_pkg::SIGN_BIAS;
            clamp_reg <= s2_clamp_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = value_reg;
    assign clamped      = clamp_reg;

    // ---------------- assertions ----------------
    `BIS_ASSERT_SAME(a_stall_only_when_full, in_stall, out_valid_reg && out_stall && s1_valid_reg && s2_valid_reg)
    `BIS_ASSERT_NEXT(a_sample_enters_pipe, do_sample, s1_valid_reg)
    `BIS_ASSERT_NEXT(a_write_no_result, in_valid && !in_stall && (action == bis_pkg::ACT_WRITE), !s1_valid_reg)
    `BIS_ASSERT_SAME(a_weights_sum_one, s1_valid_reg, (bis_pkg::WEIGHT_W+2)'(w_reg[0][0]) + (bis_pkg::WEIGHT_W+2)'(w_reg[0][1]) + (bis_pkg::WEIGHT_W+2)'(w_reg[1][0]) + (bis_pkg::WEIGHT_W+2)'(w_reg[1][1]) == (bis_pkg::WEIGHT_W+2)'(bis_pkg::WEIGHT_ONE))

endmodule
